// ===== src/conv3_pkg.sv =====
// conv3_pkg: shared widths, reset values and register index codes for the
// 3x3 image filter. No dependencies.

package conv3_pkg;

    // field widths of the stream payloads
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int COEF_W     = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int WIDTH_CFG_W = 13;
    localparam int START_CFG_W = 12;
    localparam int END_CFG_W   = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_ROI_X_START  = 3'd1,
        REG_ROI_X_END    = 3'd2,
        REG_ROI_Y_START  = 3'd3,
        REG_ROI_Y_END    = 3'd4,
        REG_KERNEL_TOP   = 3'd5,
        REG_KERNEL_MID   = 3'd6,
        REG_KERNEL_BOT   = 3'd7
    } cfg_idx_t;

    // reset values: full-image region and the sharpen kernel
    localparam logic [WIDTH_CFG_W-1:0] RST_IMAGE_WIDTH = 13'd4096;
    localparam logic [END_CFG_W-1:0]   RST_ROI_END     = 13'd4096;
    localparam logic [CFG_DATA_W-1:0]  RST_KERNEL_EDGE = 48'hFFFF_FFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0]  RST_KERNEL_MID  = 48'hFFFF_0009_FFFF;

    // largest filtered value
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

endpackage

// ===== src/conv3_ram.sv =====
// conv3_ram: generic simple dual-port RAM, one write and one read port,
// registered read data (read-first on an address collision). No dependencies.

module conv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/conv3x3_clamp_u8_unit.sv =====
// conv3x3_clamp_u8_unit: streaming 3x3 convolution of 8-bit pixels, clamped to 0..255.
// A result reaches m_ through stage 1, stage P, stage Q and the output register once the pixel
// below-right of its centre is taken. One pixel per cycle unless m_tready stalls; both line
// buffers share one 16-bit RAM read/written per pixel. Reset (aresetn low, synchronous) clears
// counters, window, pipeline valids and loads the full-image region and the sharpen kernel; line
// buffer contents are left as they are. Depends on conv3_pkg and conv3_ram.

module conv3x3_clamp_u8_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [conv3_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] pixel_in
    input  logic                               s_tuser,  // [0] frame_start
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [conv3_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [7:0] pixel_out, [19:8] out_col,
                                                         // [31:20] out_row
    // configuration writes
    input  logic                               cfg_we,
    input  logic [conv3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [conv3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import conv3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = ((WW > END_CFG_W) ? WW : END_CFG_W) + 1;
    localparam int YW = ((RW > END_CFG_W) ? RW : END_CFG_W) + 1;
    localparam int LINE_W = 2 * PIX_W;

    // saturating signed 16-bit add
    function automatic logic signed [COEF_W-1:0] sat_add(
        input logic signed [COEF_W-1:0] a,
        input logic signed [COEF_W-1:0] b
    );
        logic [COEF_W:0] s;
        s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        if (s[COEF_W] != s[COEF_W-1]) begin
            sat_add = s[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
            sat_add = s[COEF_W-1:0];
        end
    endfunction

    // configuration registers
    logic [WIDTH_CFG_W-1:0] img_width_reg;
    logic [START_CFG_W-1:0] x_start_reg;
    logic [END_CFG_W-1:0]   x_end_reg;
    logic [START_CFG_W-1:0] y_start_reg;
    logic [END_CFG_W-1:0]   y_end_reg;
    logic [CFG_DATA_W-1:0]  kern_reg [3];

    // position of the next pixel
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // stage 1: line buffer data available
    logic              v1_reg;
    logic [CW-1:0]     c1_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic              emit1_reg;
    logic [COORD_W-1:0] col1_reg, row1_reg;
    logic              fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    logic [PIX_W-1:0]  win_reg [6];

    // stage P: products
    logic               vp_reg;
    logic [COEF_W-1:0]  prod_p_reg [9];
    logic [COORD_W-1:0] col_p_reg, row_p_reg;

    // stage Q: partial sum
    logic                      vq_reg;
    logic signed [COEF_W-1:0]  acc_q_reg;
    logic [COEF_W-1:0]         prod_q_reg [4];
    logic [COORD_W-1:0]        col_q_reg, row_q_reg;

    // output register
    logic                   vo_reg;
    logic [OUT_TDATA_W-1:0] tdata_o_reg;

    // handshake chain
    logic out_free, q_free, p_free, s1_free, s1_fire, accept;

    assign out_free = !vo_reg || m_tready;
    assign q_free   = !vq_reg || out_free;
    assign p_free   = !vp_reg || q_free;
    assign s1_free  = !v1_reg || p_free;
    assign s1_fire  = v1_reg && p_free;
    assign s_tready = s1_free;
    assign accept   = s_tvalid && s1_free;

    // stage 0: position, region check, next position
    logic [CW-1:0]          c0, cc0;
    logic [RW-1:0]          r0, cr0;
    logic [XW-1:0]          w_eff, w_m1, x_end_eff;
    logic [START_CFG_W-1:0] x_start_eff, y_start_eff;
    logic                   emit0;

    always_comb begin
        c0  = s_tuser ? '0 : col_reg;
        r0  = s_tuser ? '0 : row_reg;
        cc0 = c0 - CW'(1);
        cr0 = r0 - RW'(1);

        if (XW'(img_width_reg) < XW'(3)) begin
            w_eff = XW'(3);
        end else if (XW'(img_width_reg) > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(img_width_reg);
        end
        w_m1      = w_eff - XW'(1);
        x_end_eff = (XW'(x_end_reg) < w_m1) ? XW'(x_end_reg) : w_m1;
        x_start_eff = (x_start_reg == '0) ? START_CFG_W'(1) : x_start_reg;
        y_start_eff = (y_start_reg == '0) ? START_CFG_W'(1) : y_start_reg;

        emit0 = (c0 != '0) && (r0 != '0)
             && (XW'(cc0) >= XW'(x_start_eff)) && (XW'(cc0) < x_end_eff)
             && (YW'(cr0) >= YW'(y_start_eff)) && (YW'(cr0) < YW'(y_end_reg));

        if (XW'(c0) + XW'(1) >= w_eff) begin
            col_next = '0;
            row_next = ((RW + 1)'(r0) + (RW + 1)'(1) >= (RW + 1)'(MAX_HEIGHT))
                     ? '0 : r0 + RW'(1);
        end else begin
            col_next = c0 + CW'(1);
            row_next = r0;
        end
    end

    // both line buffers in one RAM: upper row in the high byte
    logic [LINE_W-1:0] line_rdata;
    logic [PIX_W-1:0]  top1, mid1;

    assign top1 = fwd_reg ? fwd_data_reg[LINE_W-1:PIX_W] : line_rdata[LINE_W-1:PIX_W];
    assign mid1 = fwd_reg ? fwd_data_reg[PIX_W-1:0]      : line_rdata[PIX_W-1:0];

    conv3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_fire),
        .waddr (c1_reg),
        .wdata ({mid1, pix1_reg}),
        .re    (accept),
        .raddr (c0),
        .rdata (line_rdata)
    );

    // stage 1: window in kernel order and the nine truncated products
    logic [PIX_W-1:0]  taps [9];
    logic [COEF_W-1:0] prod1 [9];
    logic [COEF_W-1:0] coef;
    logic [PIX_W+COEF_W-1:0] full;

    always_comb begin
        taps[0] = win_reg[0]; taps[1] = win_reg[3]; taps[2] = top1;
        taps[3] = win_reg[1]; taps[4] = win_reg[4]; taps[5] = mid1;
        taps[6] = win_reg[2]; taps[7] = win_reg[5]; taps[8] = pix1_reg;
        coef = '0;
        full = '0;
        for (int k = 0; k < 9; k++) begin
            coef     = kern_reg[k / 3][COEF_W*(k % 3) +: COEF_W];
            full     = (PIX_W + COEF_W)'(taps[k]) * (PIX_W + COEF_W)'(coef);
            prod1[k] = full[COEF_W-1:0];
        end
    end

    // stage Q / out: saturating sums in kernel order
    logic signed [COEF_W-1:0] acc_p, acc_o;
    logic [PIX_W-1:0]         pix_o;

    always_comb begin
        acc_p = prod_p_reg[0];
        for (int k = 1; k < 5; k++) begin
            acc_p = sat_add(acc_p, prod_p_reg[k]);
        end
        acc_o = acc_q_reg;
        for (int k = 0; k < 4; k++) begin
            acc_o = sat_add(acc_o, prod_q_reg[k]);
        end
        if (acc_o < 0) begin
            pix_o = '0;
        end else if (acc_o > signed'(COEF_W'(PIX_MAX))) begin
            pix_o = PIX_MAX;
        end else begin
            pix_o = acc_o[PIX_W-1:0];
        end
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_width_reg <= RST_IMAGE_WIDTH;
            x_start_reg   <= '0;
            x_end_reg     <= RST_ROI_END;
            y_start_reg   <= '0;
            y_end_reg     <= RST_ROI_END;
            kern_reg[0]   <= RST_KERNEL_EDGE;
            kern_reg[1]   <= RST_KERNEL_MID;
            kern_reg[2]   <= RST_KERNEL_EDGE;
            col_reg       <= '0;
            row_reg       <= '0;
            v1_reg        <= 1'b0;
            fwd_reg       <= 1'b0;
            vp_reg        <= 1'b0;
            vq_reg        <= 1'b0;
            vo_reg        <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_IMAGE_WIDTH: img_width_reg <= cfg_wdata[WIDTH_CFG_W-1:0];
                    REG_ROI_X_START: x_start_reg   <= cfg_wdata[START_CFG_W-1:0];
                    REG_ROI_X_END:   x_end_reg     <= cfg_wdata[END_CFG_W-1:0];
                    REG_ROI_Y_START: y_start_reg   <= cfg_wdata[START_CFG_W-1:0];
                    REG_ROI_Y_END:   y_end_reg     <= cfg_wdata[END_CFG_W-1:0];
                    REG_KERNEL_TOP:  kern_reg[0]   <= cfg_wdata;
                    REG_KERNEL_MID:  kern_reg[1]   <= cfg_wdata;
                    REG_KERNEL_BOT:  kern_reg[2]   <= cfg_wdata;
                endcase
            end
            // accepted pixel moves the position and enters stage 1
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                // the stage 1 pixel writes the same entry this cycle
                fwd_reg <= v1_reg && (c1_reg == c0);
            end
            if (s1_free) begin
                v1_reg <= accept;
            end
            // window shifts as each pixel leaves stage 1
            if (s1_fire) begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top1;
                win_reg[4] <= mid1;
                win_reg[5] <= pix1_reg;
            end
            if (p_free) begin
                vp_reg <= v1_reg && emit1_reg;
            end
            if (q_free) begin
                vq_reg <= vp_reg;
            end
            if (out_free) begin
                vo_reg <= vq_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            c1_reg       <= c0;
            pix1_reg     <= s_tdata[PIX_W-1:0];
            emit1_reg    <= emit0;
            col1_reg     <= COORD_W'(cc0);
            row1_reg     <= COORD_W'(cr0);
            fwd_data_reg <= {mid1, pix1_reg};
        end
        if (p_free) begin
            prod_p_reg <= prod1;
            col_p_reg  <= col1_reg;
            row_p_reg  <= row1_reg;
        end
        if (q_free) begin
            acc_q_reg <= acc_p;
            for (int k = 0; k < 4; k++) begin
                prod_q_reg[k] <= prod_p_reg[k + 5];
            end
            col_q_reg <= col_p_reg;
            row_q_reg <= row_p_reg;
        end
        if (out_free) begin
            tdata_o_reg <= {row_q_reg, col_q_reg, pix_o};
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = tdata_o_reg;

endmodule

// ===== test/tb_conv3x3_clamp_u8_unit.sv =====
// tb_conv3x3_clamp_u8_unit: self-checking testbench for the streaming 3x3 clamp filter.
// Holds its own model of line stores, window and counters to predict every result.
// Depends on conv3_pkg and the conv3x3_clamp_u8_unit RTL.

module tb_conv3x3_clamp_u8_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import conv3_pkg::*;

    localparam int LINE_DEPTH     = 4096;
    localparam int ROW_LIMIT      = 4096;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_LEN       = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 620;

    typedef struct packed {
        logic       fs;
        logic [7:0] pix;
    } src_px_t;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0]  pix;
    } filt_px_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // [7:0] pixel_in
    logic                   s_tuser = 1'b0;   // [0] frame_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [7:0] pixel_out, [19:8] out_col, [31:20] out_row
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    conv3x3_clamp_u8_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // pixels waiting to be sent and filtered pixels waiting to arrive
    src_px_t  pending_px[$];
    filt_px_t filtered_q[$];
    src_px_t  next_px;
    filt_px_t want_px;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap = 0;
    int snk_hold = 0;
    bit stall_req = 1'b0;
    bit stall_taken = 1'b0;
    int mismatch_count = 0;

    // filter model state and register copies
    logic [7:0]  upper_line [LINE_DEPTH];
    logic [7:0]  lower_line [LINE_DEPTH];
    logic [7:0]  win [6];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [12:0] img_width;
    logic [11:0] x_first;
    logic [12:0] x_bound;
    logic [11:0] y_first;
    logic [12:0] y_bound;
    logic [47:0] kernel_rows [3];

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // filter model: takes one pixel, queues the filtered centre if one falls due
    function automatic void predict_filter(input logic [7:0] pix, input logic fs);
        int unsigned w, c, r, xs, xe, ys, cc, cr;
        logic [7:0]  top, mid;
        logic [7:0]  nb [9];
        logic [15:0] coef, prod;
        int          sum;
        filt_px_t    res;
        w = img_width;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos % LINE_DEPTH;
        r = row_pos % ROW_LIMIT;
        top = upper_line[c];
        mid = lower_line[c];
        upper_line[c] = mid;
        lower_line[c] = pix;
        // neighbourhood in kernel order, top-left first
        nb[0] = win[0]; nb[1] = win[3]; nb[2] = top;
        nb[3] = win[1]; nb[4] = win[4]; nb[5] = mid;
        nb[6] = win[2]; nb[7] = win[5]; nb[8] = pix;
        xs = (x_first == 0) ? 1 : x_first;
        xe = (x_bound < w - 1) ? x_bound : w - 1;
        ys = (y_first == 0) ? 1 : y_first;
        if (c >= 1 && r >= 1) begin
            cc = c - 1;
            cr = r - 1;
            if (cc >= xs && cc < xe && cr >= ys && cr < y_bound) begin
                sum = 0;
                for (int k = 0; k < 9; k++) begin
                    coef = kernel_rows[k / 3][16 * (k % 3) +: 16];
                    prod = {8'd0, nb[k]} * coef;
                    sum = sum + int'($signed(prod));
                    if (sum > 32767) sum = 32767;
                    if (sum < -32768) sum = -32768;
                end
                if (sum < 0) sum = 0;
                if (sum > 255) sum = 255;
                res.pix = sum[7:0];
                res.col = cc[11:0];
                res.row = cr[11:0];
                filtered_q.push_back(res);
            end
        end
        win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
        win[3] = top;    win[4] = mid;    win[5] = pix;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= ROW_LIMIT) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    // input driver: sends queued pixels, predicts on each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_filter(s_tdata[7:0], s_tuser);
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_px.size() > 0 && $urandom_range(99) < src_idle_pct) begin
                    src_gap = $urandom_range(1, 14) - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_px.size() > 0) begin
                    next_px = pending_px.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_px.pix;
                    s_tuser  <= next_px.fs;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each filtered pixel, drives ready with stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (filtered_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want_px = filtered_q.pop_front();
                    if (m_tdata[7:0] !== want_px.pix) begin
                        $display("%0t: pixel_out expected %0d, got %0d",
                                 $time, want_px.pix, m_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[19:8] !== want_px.col) begin
                        $display("%0t: out_col expected %0d, got %0d",
                                 $time, want_px.col, m_tdata[19:8]);
                        mismatch_count++;
                    end
                    if (m_tdata[31:20] !== want_px.row) begin
                        $display("%0t: out_row expected %0d, got %0d",
                                 $time, want_px.row, m_tdata[31:20]);
                        mismatch_count++;
                    end
                end
            end
            // one long hold-off to back the block up into its input
            if (stall_req && !stall_taken) begin
                stall_taken = 1'b1;
                snk_hold = HOLD_LEN;
            end
            if (snk_hold > 0) begin
                snk_hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(99) < snk_idle_pct) begin
                snk_hold = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb_conv3x3_clamp_u8_unit NOT OK");
        $finish;
    end

    function automatic logic [7:0] rand_pixel();
        if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // three coefficients of one kernel row, from several value families
    function automatic logic [47:0] rand_kernel_row();
        logic [15:0] c [3];
        int          mode, v;
        mode = $urandom_range(6);
        for (int i = 0; i < 3; i++) begin
            case (mode)
                0: c[i] = 16'($urandom);
                1: c[i] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                2: c[i] = $urandom_range(1) ? 16'h0080 : 16'hFF80;
                3: c[i] = 16'h0000;
                4: c[i] = 16'hFFFF;
                default: begin
                    v = int'($urandom_range(8)) - 4;
                    c[i] = v[15:0];
                end
            endcase
        end
        return {c[2], c[1], c[0]};
    endfunction

    task automatic queue_pixels(input int count, input bit first_fs, input int noise_pct);
        src_px_t px;
        for (int i = 0; i < count; i++) begin
            px.fs  = (i == 0 && first_fs) || ($urandom_range(99) < noise_pct);
            px.pix = rand_pixel();
            pending_px.push_back(px);
        end
    endtask

    // wait until every pixel is sent and every result is in, then let the pipe empty
    task automatic wait_idle();
        while (pending_px.size() != 0 || s_tvalid || filtered_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [47:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_IMAGE_WIDTH: img_width      = value[12:0];
            REG_ROI_X_START: x_first        = value[11:0];
            REG_ROI_X_END:   x_bound        = value[12:0];
            REG_ROI_Y_START: y_first        = value[11:0];
            REG_ROI_Y_END:   y_bound        = value[12:0];
            REG_KERNEL_TOP:  kernel_rows[0] = value;
            REG_KERNEL_MID:  kernel_rows[1] = value;
            REG_KERNEL_BOT:  kernel_rows[2] = value;
            default: ;
        endcase
    endtask

    task automatic set_region(input logic [12:0] width, input logic [11:0] xs,
                              input logic [12:0] xe, input logic [11:0] ys,
                              input logic [12:0] ye, input logic [47:0] ktop,
                              input logic [47:0] kmid, input logic [47:0] kbot);
        write_reg(REG_IMAGE_WIDTH, 48'(width));
        write_reg(REG_ROI_X_START, 48'(xs));
        write_reg(REG_ROI_X_END, 48'(xe));
        write_reg(REG_ROI_Y_START, 48'(ys));
        write_reg(REG_ROI_Y_END, 48'(ye));
        write_reg(REG_KERNEL_TOP, ktop);
        write_reg(REG_KERNEL_MID, kmid);
        write_reg(REG_KERNEL_BOT, kbot);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        src_px_t     px;
        int          rnd_items, width, weff, rows, count;
        logic [11:0] xs, ys;
        logic [12:0] xe, ye;

        // model after reset
        for (int i = 0; i < 6; i++) win[i] = 8'd0;
        col_pos = 0;
        row_pos = 0;
        img_width = RST_IMAGE_WIDTH;
        x_first = '0;
        x_bound = RST_ROI_END;
        y_first = '0;
        y_bound = RST_ROI_END;
        kernel_rows[0] = RST_KERNEL_EDGE;
        kernel_rows[1] = RST_KERNEL_MID;
        kernel_rows[2] = RST_KERNEL_EDGE;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // directed: 5-wide frame of extreme pixels, sharpen kernel, then a restart mid-row
        src_idle_pct = 5;
        snk_idle_pct = 5;
        set_region(13'd5, 12'd0, 13'd8191, 12'd0, 13'd8191,
                   RST_KERNEL_EDGE, RST_KERNEL_MID, RST_KERNEL_EDGE);
        for (int i = 0; i < 18; i++) begin
            px.fs = (i == 0);
            case (i / 5)
                0: px.pix = (i % 2) ? 8'hFF : 8'h00;
                1: px.pix = 8'hFF;
                2: px.pix = 8'h00;
                default: px.pix = (i % 2) ? 8'h00 : 8'hFF;
            endcase
            pending_px.push_back(px);
        end
        px.fs = 1'b1;
        px.pix = 8'h80;
        pending_px.push_back(px);
        queue_pixels(4, 1'b0, 0);
        wait_idle();

        // long receiver hold-off while the sender keeps offering
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_region(13'd8, 12'd0, 13'd8191, 12'd0, 13'd8191,
                   rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        stall_req = 1'b1;
        queue_pixels(8 * 20, 1'b1, 0);
        wait_idle();

        // width shrinks while the column count is already past the new width
        src_idle_pct = 5;
        snk_idle_pct = 5;
        set_region(13'd10, 12'd0, 13'd8191, 12'd0, 13'd8191,
                   rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        queue_pixels(26, 1'b1, 0);
        wait_idle();
        set_region(13'd4, 12'd0, 13'd8191, 12'd0, 13'd8191,
                   rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        queue_pixels(20, 1'b0, 0);
        wait_idle();

        // empty region with every start and end at its extreme
        set_region(13'd6, 12'd4095, 13'd0, 12'd4095, 13'd0,
                   48'h0, 48'hFFFF_FFFF_FFFF, 48'h7FFF_8000_7FFF);
        queue_pixels(30, 1'b1, 0);
        wait_idle();

        // width above the maximum: start of a first row, no centre due yet
        set_region(13'd8191, 12'd4090, 13'd8191, 12'd0, 13'd8191,
                   rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        queue_pixels(40, 1'b1, 0);
        wait_idle();

        // width below three acts as three
        set_region(13'd0, 12'd0, 13'd8191, 12'd0, 13'd8191,
                   rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        queue_pixels(3 * 8, 1'b1, 0);
        wait_idle();

        // random frames with random regions, kernels and idling
        rnd_items = 0;
        while (rnd_items < RANDOM_ITEMS) begin
            width = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
            weff = (width < 3) ? 3 : width;
            if ($urandom_range(2) == 0) begin
                xs = '0;
                xe = 13'd8191;
                ys = '0;
                ye = 13'd8191;
            end else begin
                xs = ($urandom_range(9) == 0) ? 12'd4095 : 12'($urandom_range(weff - 1));
                xe = ($urandom_range(9) == 0) ? 13'd8191 : 13'($urandom_range(weff + 1));
                ys = ($urandom_range(9) == 0) ? 12'd4095 : 12'($urandom_range(3));
                ye = ($urandom_range(9) == 0) ? 13'd8191 : 13'($urandom_range(8));
            end
            rows = $urandom_range(3, 10);
            count = rows * weff + $urandom_range(weff - 1);
            case ($urandom_range(2))
                0: src_idle_pct = 0;
                1: src_idle_pct = 4;
                default: src_idle_pct = 15;
            endcase
            case ($urandom_range(2))
                0: snk_idle_pct = 0;
                1: snk_idle_pct = 4;
                default: snk_idle_pct = 15;
            endcase
            set_region(13'(width), xs, xe, ys, ye,
                       rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
            queue_pixels(count, 1'b1, 2);
            rnd_items += count;
            wait_idle();
        end

        // closing frame with no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_region(13'd7, 12'd0, 13'd8191, 12'd0, 13'd8191,
                   rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        queue_pixels(7 * 9, 1'b1, 0);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("tb_conv3x3_clamp_u8_unit OK");
        end else begin
            $display("tb_conv3x3_clamp_u8_unit NOT OK");
        end
        $finish;
    end

endmodule
